FILE: src/nearest_point_search_3d_macros.svh
// assertion helpers for the nearest point search block
// the module that uses them provides clk_i and rst_ni
`ifndef NEAREST_POINT_SEARCH_3D_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_MACROS_SVH

`ifndef SYNTHESIS

`define NPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nps: property failed");

`define NPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nps: implication failed");

`define NPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nps: next-cycle implication failed");

`else

`define NPS_ASSERT(lbl, prop)
`define NPS_ASSERT_IMP(lbl, ante, cons)
`define NPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/nps_pkg.sv
package nps_pkg;

  // field widths
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CountW  = 13;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned SqW     = 2 * CoordW;
  localparam int unsigned DistW   = SqW + 2;
  localparam int unsigned PointW  = 3 * CoordW;

  // default table depth
  localparam int unsigned MaxPointsDef = 4096;

  // op codes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // axis select codes
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

endpackage

FILE: src/nearest_point_search_3d.sv
// Brute-force nearest point search over a table of up to MAX_POINTS 3D points in signed
// Q16.16. A load beat (op 0) writes one point at point_index and gives no
// result; an index at or beyond MAX_POINTS is dropped. A query beat (op 1) scans entries 0 to
// point_count-1 (point_count saturates at MAX_POINTS) and returns the entry with the smallest
// exact squared distance, the lowest index winning a tie; with a count of zero the query
// position comes back unchanged. Each stored point takes one table read, then for each of
// the three axes an absolute-difference step, a pass through the single shared 32x32
// multiplier and a 66-bit accumulate, then one compare against the best so far. in_stall_o
// stays high from accept until the best point is written to the result register. The result
// sits in an output register, so loads are taken while it waits; a second query waits for
// that register to drain before finishing. The table has no clearing pass after reset:
// every entry a query scans must have been loaded first.
`include "nearest_point_search_3d_macros.svh"

module nearest_point_search_3d
  import nps_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CountW-1:0]        cfg_data_i,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [IndexW-1:0]        point_index_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] nearest_x_o,
  output logic signed [CoordW-1:0] nearest_y_o,
  output logic signed [CoordW-1:0] nearest_z_o
);

  // table address and a scan counter that can also hold the full depth
  localparam int unsigned AddrW = $clog2(MAX_POINTS);
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam logic [31:0] MaxPts32 = 32'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]        count_q, count_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [CntW-1:0]          n_q, n_d;
  logic [1:0]               axis_q, axis_d;
  logic                     have_q, have_d;

  // query position and best point so far
  logic [CoordW-1:0]        qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic [CoordW-1:0]        bx_q, bx_d, by_q, by_d, bz_q, bz_d;
  logic [DistW-1:0]         best_q, best_d;

  // shared datapath registers
  logic [CoordW-1:0]        mag_q, mag_d;
  logic [SqW-1:0]           sq_q, sq_d;
  logic [DistW-1:0]         acc_q, acc_d;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic [CoordW-1:0]        ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;

  // table port
  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [PointW-1:0]        ram_wdata;
  logic                     ram_re;
  logic [PointW-1:0]        ram_rdata;
  logic [CoordW-1:0]        pt_x, pt_y, pt_z;

  // abs difference operands
  logic [CoordW-1:0]        sel_p, sel_q;
  logic signed [CoordW:0]   diff;

  logic [CntW-1:0]          n_sat;
  logic                     in_accept;
  logic                     idx_in_range;

  // points are stored as {z, y, x}
  nps_ram #(
    .WIDTH (PointW),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign pt_x = ram_rdata[CoordW-1:0];
  assign pt_y = ram_rdata[2*CoordW-1:CoordW];
  assign pt_z = ram_rdata[3*CoordW-1:2*CoordW];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // a count above the table depth searches the whole table
  assign n_sat = (32'(count_q) > MaxPts32) ? CntW'(MaxPts32) : CntW'(count_q);
  assign idx_in_range = (32'(point_index_i) < MaxPts32);

  // loads go straight into the table while idle
  assign ram_we    = in_accept && (op_i == OpLoad) && idx_in_range;
  assign ram_waddr = AddrW'(point_index_i);
  assign ram_wdata = {coord_z_i, coord_y_i, coord_x_i};
  assign ram_re    = (state_q == S_READ);

  // axis mux into the shared abs-difference stage
  always_comb begin
    case (axis_q)
      AxisX: begin
        sel_p = pt_x;
        sel_q = qx_q;
      end
      AxisY: begin
        sel_p = pt_y;
        sel_q = qy_q;
      end
      AxisZ: begin
        sel_p = pt_z;
        sel_q = qz_q;
      end
      default: begin
        sel_p = pt_x;
        sel_q = qx_q;
      end
    endcase
  end

  // magnitude of a 33-bit difference always fits in 32 bits
  assign diff = $signed({sel_p[CoordW-1], sel_p}) - $signed({sel_q[CoordW-1], sel_q});

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    n_d         = n_q;
    axis_d      = axis_q;
    have_d      = have_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    qz_d        = qz_q;
    bx_d        = bx_q;
    by_d        = by_q;
    bz_d        = bz_q;
    best_d      = best_q;
    mag_d       = mag_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oz_d        = oz_q;

    if (cfg_valid_i && cfg_ready_o) begin
      count_d = cfg_data_i;
    end

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (op_i == OpQuery)) begin
          qx_d   = coord_x_i;
          qy_d   = coord_y_i;
          qz_d   = coord_z_i;
          // empty table returns the query position
          bx_d   = coord_x_i;
          by_d   = coord_y_i;
          bz_d   = coord_z_i;
          have_d = 1'b0;
          idx_d  = '0;
          n_d    = n_sat;
          if (n_sat == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        acc_d   = '0;
        axis_d  = AxisX;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        mag_d   = diff[CoordW] ? CoordW'(-diff) : diff[CoordW-1:0];
        state_d = S_MUL;
      end
      S_MUL: begin
        sq_d    = mag_q * mag_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = acc_q + DistW'(sq_q);
        if (axis_q == AxisZ) begin
          state_d = S_CMP;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_DIFF;
        end
      end
      S_CMP: begin
        // strict less keeps the lowest index on a tie
        if (!have_q || (acc_q < best_q)) begin
          have_d = 1'b1;
          best_d = acc_q;
          bx_d   = pt_x;
          by_d   = pt_y;
          bz_d   = pt_z;
        end
        if ((idx_q + CntW'(1)) == n_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_READ;
        end
      end
      S_DONE: begin
        // wait for the result register to be free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          ox_d        = bx_q;
          oy_d        = by_q;
          oz_d        = bz_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      axis_q      <= AxisX;
      have_q      <= 1'b0;
      qx_q        <= '0;
      qy_q        <= '0;
      qz_q        <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      bz_q        <= '0;
      best_q      <= '0;
      mag_q       <= '0;
      sq_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      oz_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      axis_q      <= axis_d;
      have_q      <= have_d;
      qx_q        <= qx_d;
      qy_q        <= qy_d;
      qz_q        <= qz_d;
      bx_q        <= bx_d;
      by_q        <= by_d;
      bz_q        <= bz_d;
      best_q      <= best_d;
      mag_q       <= mag_d;
      sq_q        <= sq_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      oz_q        <= oz_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign nearest_x_o = ox_q;
  assign nearest_y_o = oy_q;
  assign nearest_z_o = oz_q;

  // the scan never compares past the searched count
  `NPS_ASSERT_IMP(a_cmp_in_range, state_q == S_CMP, idx_q < n_q)
  // the table is only written while no query is running
  `NPS_ASSERT_IMP(a_write_idle, ram_we, state_q == S_IDLE)
  // a finished query always lands in the result register
  `NPS_ASSERT_NEXT(a_done_to_out, (state_q == S_DONE) && (!out_valid_q || !out_stall_i), out_valid_o)
  // accumulation only grows the distance
  `NPS_ASSERT_NEXT(a_acc_grows, state_q == S_ACC, acc_q >= $past(acc_q))

endmodule

FILE: src/nps_ram.sv
module nps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nps_pkg::*;

  // one stored point or one query position, signed q16.16 per axis
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // timeout, several times the slowest legal run with every query over the whole window
  localparam int unsigned CycleLimit = 500_000;
  // entries 0 .. WindowLen-1 are all loaded before any random query scans them
  localparam int unsigned WindowLen = 48;

  // clock, reset and block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [CountW-1:0]  cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               op_i          = OpLoad;
  logic [IndexW-1:0]  point_index_i = '0;
  logic signed [CoordW-1:0] coord_x_i = '0;
  logic signed [CoordW-1:0] coord_y_i = '0;
  logic signed [CoordW-1:0] coord_z_i = '0;
  logic               out_stall_i   = 1'b0;

  // block outputs
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [CoordW-1:0] nearest_x_o;
  logic signed [CoordW-1:0] nearest_y_o;
  logic signed [CoordW-1:0] nearest_z_o;

  // shadow of the point table and of the count register
  point_t            pts [MaxPointsDef];
  logic [CountW-1:0] search_count = '0;

  // nearest points still owed by the block, oldest first
  point_t expected_nearest [$];
  point_t exp_pt;

  // idle mix, in percent of cycles
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  int unsigned fail_count      = 0;
  int unsigned loads_sent      = 0;
  int unsigned queries_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned cycle_count     = 0;

  nearest_point_search_3d uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .point_index_i (point_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .nearest_x_o   (nearest_x_o),
    .nearest_y_o   (nearest_y_o),
    .nearest_z_o   (nearest_z_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // square of one axis difference; the magnitude stays below 2^32
  function automatic logic [SqW-1:0] axis_sq(logic signed [CoordW-1:0] a,
                                             logic signed [CoordW-1:0] b);
    logic [CoordW:0]   diff;
    logic [CoordW-1:0] mag;
    diff = {a[CoordW-1], a} - {b[CoordW-1], b};
    mag  = diff[CoordW] ? (~diff[CoordW-1:0] + 1'b1) : diff[CoordW-1:0];
    return {{CoordW{1'b0}}, mag} * {{CoordW{1'b0}}, mag};
  endfunction

  // exact squared euclidean distance, no wrap at 66 bits
  function automatic logic [DistW-1:0] sq_dist(point_t a, point_t b);
    return {2'b00, axis_sq(a.x, b.x)} + {2'b00, axis_sq(a.y, b.y)}
         + {2'b00, axis_sq(a.z, b.z)};
  endfunction

  // scan entries from zero; strict compare keeps the lowest index on a tie,
  // and an empty scan hands the query position back
  function automatic point_t nearest_stored(point_t q);
    point_t           best;
    logic [DistW-1:0] best_d;
    logic [DistW-1:0] d;
    int               n;
    best   = q;
    best_d = '0;
    n = (search_count > MaxPointsDef) ? MaxPointsDef : int'(search_count);
    for (int i = 0; i < n; i++) begin
      d = sq_dist(pts[i], q);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best   = pts[i];
      end
    end
    return best;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_nearest.size() == 0) begin
        $error("result beat with no query waiting: x %0d y %0d z %0d",
               nearest_x_o, nearest_y_o, nearest_z_o);
        fail_count++;
      end else begin
        exp_pt = expected_nearest.pop_front();
        if (nearest_x_o !== exp_pt.x) begin
          $error("nearest_x: expected %0d, got %0d", exp_pt.x, nearest_x_o);
          fail_count++;
        end
        if (nearest_y_o !== exp_pt.y) begin
          $error("nearest_y: expected %0d, got %0d", exp_pt.y, nearest_y_o);
          fail_count++;
        end
        if (nearest_z_o !== exp_pt.z) begin
          $error("nearest_z: expected %0d, got %0d", exp_pt.z, nearest_z_o);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends just after a rising edge
  // ---------------------------------------------------------------------------

  // one input beat; valid stays high afterwards so beats can go back to back
  task automatic send_beat(input logic op, input logic [IndexW-1:0] idx,
                           input point_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    point_index_i <= idx;
    coord_x_i     <= p.x;
    coord_y_i     <= p.y;
    coord_z_i     <= p.z;
    do @(posedge clk_i); while (in_stall_o);
    // beat taken at this edge: table state and count are what the block sees
    if (op == OpLoad) begin
      if (int'(idx) < MaxPointsDef) pts[idx] = p;
      loads_sent++;
    end else begin
      expected_nearest.push_back(nearest_stored(p));
      queries_sent++;
    end
  endtask

  function automatic point_t mk_point(logic signed [CoordW-1:0] x,
                                      logic signed [CoordW-1:0] y,
                                      logic signed [CoordW-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // drop valid, wait for every owed result, then let a trailing load settle
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (expected_nearest.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // count register write, only ever issued with the block idle
  task automatic write_count(input logic [CountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    search_count = value;
    cfg_writes++;
  endtask

  // mix of full-range, extreme and small values so ties and near hits happen
  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return {1'b0, {(CoordW-1){1'b1}}};
      1:       return {1'b1, {(CoordW-1){1'b0}}};
      2, 3:    return $urandom;
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic point_t rand_point();
    return mk_point(rand_coord(), rand_coord(), rand_coord());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // count still at its reset value of zero: the position comes straight back
  task automatic test_empty_table();
    drain_block();
    send_beat(OpQuery, '0, mk_point(32'sh7fffffff, 32'sh80000000, 32'sd0));
    send_beat(OpQuery, {IndexW{1'b1}}, mk_point(-32'sd1, 32'sd1, 32'sh80000000));
  endtask

  // corners of the coordinate range, largest possible distances
  task automatic test_extreme_coords();
    send_beat(OpLoad, 12'd0, mk_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_beat(OpLoad, 12'd1, mk_point(32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_beat(OpLoad, 12'd2, mk_point(32'sd0, 32'sd0, 32'sd0));
    drain_block();
    write_count(13'd3);
    send_beat(OpQuery, '0, mk_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_beat(OpQuery, '0, mk_point(32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_beat(OpQuery, '0, mk_point(32'sd1, -32'sd1, 32'sd0));
    send_beat(OpQuery, '0, mk_point(32'sh80000000, 32'sh7fffffff, 32'sd0));
  endtask

  // equal distances: the lowest index must win
  task automatic test_tie_first_wins();
    send_beat(OpLoad, 12'd0, mk_point(32'sd10, 32'sd0, 32'sd0));
    send_beat(OpLoad, 12'd1, mk_point(-32'sd10, 32'sd0, 32'sd0));
    send_beat(OpLoad, 12'd2, mk_point(32'sd10, 32'sd0, 32'sd0));
    // top index, outside the scanned range here
    send_beat(OpLoad, {IndexW{1'b1}}, mk_point(32'sd0, 32'sd0, 32'sd0));
    drain_block();
    write_count(13'd3);
    send_beat(OpQuery, '0, mk_point(32'sd0, 32'sd0, 32'sd0));
    send_beat(OpQuery, '0, mk_point(32'sd10, 32'sd0, 32'sd0));
  endtask

  // every entry of the scan window loaded, then scans over the whole window
  task automatic test_window_scan();
    for (int i = 0; i < WindowLen; i++) begin
      send_beat(OpLoad, IndexW'(i), rand_point());
    end
    drain_block();
    write_count(CountW'(WindowLen));
    // hit on the last scanned entry
    send_beat(OpQuery, '0, pts[WindowLen-1]);
    send_beat(OpQuery, '0, rand_point());
    drain_block();
    write_count('0);
    send_beat(OpQuery, '0, rand_point());
  endtask

  // one random beat; the scan window is fully written, so any scanned entry is legal
  task automatic random_beat();
    int               r;
    int               cnt;
    point_t           p;
    logic [IndexW-1:0] idx;
    r   = $urandom_range(0, 99);
    cnt = (search_count > MaxPointsDef) ? MaxPointsDef : int'(search_count);
    if (r < 35) begin
      // loads mostly land in the low 64 entries, around the scanned window
      idx = ($urandom_range(0, 3) == 0) ? IndexW'($urandom_range(0, MaxPointsDef-1))
                                        : IndexW'($urandom_range(0, 63));
      // some loads duplicate another entry to force ties
      p = ($urandom_range(0, 9) == 0) ? pts[$urandom_range(0, WindowLen-1)] : rand_point();
      send_beat(OpLoad, idx, p);
    end else begin
      if (cnt == 0 || r >= 85) begin
        p = rand_point();
      end else begin
        p = pts[$urandom_range(0, cnt-1)];
        if (r < 75) begin
          // nudge around a stored point
          p.x = p.x + (int'($urandom_range(0, 64)) - 32);
          p.y = p.y + (int'($urandom_range(0, 64)) - 32);
          p.z = p.z + (int'($urandom_range(0, 64)) - 32);
        end
      end
      send_beat(OpQuery, IndexW'($urandom), p);
    end
  endtask

  // bursts of random beats, each under a fresh count
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      drain_block();
      write_count(($urandom_range(0, 99) < 8) ? '0 : CountW'($urandom_range(1, WindowLen)));
      repeat ($urandom_range(4, 12)) begin
        random_beat();
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender gaps light, receiver stalls heavy
    tx_idle_pct = 28;
    rx_idle_pct = 87;
    test_empty_table();
    test_extreme_coords();
    test_tie_first_wins();
    test_window_scan();
    test_random_traffic(22);

    // the other way round
    drain_block();
    tx_idle_pct = 87;
    rx_idle_pct = 28;
    test_random_traffic(22);

    // full throughput
    drain_block();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(22);

    drain_block();
    repeat (32) @(posedge clk_i);

    $display("tb: %0d loads, %0d queries, %0d results checked, %0d count writes",
             loads_sent, queries_sent, results_checked, cfg_writes);
    $display("tb: ran empty table, coordinate corners, ties and whole-window scans,");
    $display("tb: then random loads and queries under three idle mixes");
    if (fail_count == 0 && expected_nearest.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
